>>> rtl/ght_pkg.sv
// Shared types and constants for the generational handle table.
`timescale 1ns / 1ps
package ght_pkg;

  localparam int ENTRIES_DEF      = 4096;
  localparam int GEN_BITS_DEF     = 15;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int TYPE_W           = 5;
  localparam int OP_W             = 2;
  localparam int STATUS_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } state_t;

  // control part of a queued request
  typedef struct packed {
    op_t  op;
    logic idx_ok;
  } req_ctrl_t;

endpackage

>>> rtl/ght_front.sv
// Request intake: range check of the handle index and a two-entry request queue.
`timescale 1ns / 1ps
module ght_front import ght_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int GEN_BITS     = GEN_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W       = $clog2(ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [IDX_W-1:0]        in_handle_index,
  input  logic [GEN_BITS-1:0]     in_handle_generation,
  input  logic [TYPE_W-1:0]       in_handle_type,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic                    clearing,
  input  logic                    q_pop,
  output logic                    q_valid,
  output req_ctrl_t               q_ctrl,
  output logic [IDX_W-1:0]        q_idx,
  output logic [GEN_BITS-1:0]     q_gen,
  output logic [TYPE_W-1:0]       q_typ,
  output logic [PAYLOAD_BITS-1:0] q_pay
);

  localparam int QD = 2;

  req_ctrl_t               ctrl_r [QD];
  logic [IDX_W-1:0]        idx_r  [QD];
  logic [GEN_BITS-1:0]     gen_r  [QD];
  logic [TYPE_W-1:0]       typ_r  [QD];
  logic [PAYLOAD_BITS-1:0] pay_r  [QD];

  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  req_ctrl_t  in_ctrl;

  assign in_stall = clearing || (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall;

  always_comb begin
    in_ctrl.op     = op_t'(in_opcode);
    in_ctrl.idx_ok = {1'b0, in_handle_index} < (IDX_W+1)'(ENTRIES);
  end

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_r[wr_ptr_r] <= in_ctrl;
      idx_r[wr_ptr_r]  <= in_handle_index;
      gen_r[wr_ptr_r]  <= in_handle_generation;
      typ_r[wr_ptr_r]  <= in_handle_type;
      pay_r[wr_ptr_r]  <= in_payload;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_ctrl  = ctrl_r[rd_ptr_r];
  assign q_idx   = idx_r[rd_ptr_r];
  assign q_gen   = gen_r[rd_ptr_r];
  assign q_typ   = typ_r[rd_ptr_r];
  assign q_pay   = pay_r[rd_ptr_r];

endmodule

>>> rtl/ght_back.sv
// Slot store, free list and result register: executes one request at a time.
`timescale 1ns / 1ps
module ght_back import ght_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int GEN_BITS     = GEN_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W       = $clog2(ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  req_ctrl_t               q_ctrl,
  input  logic [IDX_W-1:0]        q_idx,
  input  logic [GEN_BITS-1:0]     q_gen,
  input  logic [TYPE_W-1:0]       q_typ,
  input  logic [PAYLOAD_BITS-1:0] q_pay,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [IDX_W-1:0]        out_new_index,
  output logic [GEN_BITS-1:0]     out_new_generation,
  output logic [TYPE_W-1:0]       out_new_type,
  output logic [PAYLOAD_BITS-1:0] out_payload_out,
  output logic [IDX_W-1:0]        out_live_count
);

  // slot word: {active, generation, next free}
  localparam int SLOT_W = 1 + GEN_BITS + IDX_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  logic [SLOT_W-1:0]       slot_mem [ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem  [ENTRIES];
  logic [SLOT_W-1:0]       slot_rd_r;
  logic [PAYLOAD_BITS-1:0] pay_rd_r;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic [IDX_W-1:0] active_r, active_nxt;

  req_ctrl_t               cur_ctrl_r;
  logic [IDX_W-1:0]        cur_idx_r;
  logic [GEN_BITS-1:0]     cur_gen_r;
  logic [TYPE_W-1:0]       cur_typ_r;
  logic [PAYLOAD_BITS-1:0] cur_pay_r;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, res_status;
  logic [IDX_W-1:0]        out_idx_r, res_idx;
  logic [GEN_BITS-1:0]     out_gen_r, res_gen;
  logic [TYPE_W-1:0]       out_typ_r, res_typ;
  logic [PAYLOAD_BITS-1:0] out_pay_r, res_pay;
  logic [IDX_W-1:0]        out_live_r;

  logic                    fire, rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    slot_we, pay_we;
  logic [IDX_W-1:0]        slot_wa;
  logic [SLOT_W-1:0]       slot_wd;

  logic                    rd_active;
  logic [GEN_BITS-1:0]     rd_gen, gen_inc;
  logic [IDX_W-1:0]        rd_next;
  logic                    add_ok, hdl_ok;

  assign rd_active = slot_rd_r[SLOT_W-1];
  assign rd_gen    = slot_rd_r[SLOT_W-2:IDX_W];
  assign rd_next   = slot_rd_r[IDX_W-1:0];

  // the result register must be free or emptying before a request retires
  assign fire = (state_r == BK_EXEC) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_cnt_r == LAST) state_nxt = BK_IDLE;
      BK_IDLE:  if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC:  if (fire) state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing = 1'b0;
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    case (state_r)
      BK_CLEAR: clearing = 1'b1;
      BK_IDLE: begin
        q_pop = q_valid;
        rd_en = q_valid;
      end
      BK_EXEC: ;
      default: clearing = 1'b1;
    endcase
  end

  // read address: the free head for add, otherwise the handle slot for an in-range index, else slot 0
  always_comb begin
    if (q_ctrl.op == OP_ADD) rd_addr = free_head_r;
    else if (q_ctrl.idx_ok)  rd_addr = q_idx;
    else                     rd_addr = '0;
  end

  always_comb begin
    gen_inc = rd_gen + GEN_BITS'(1);
    if (gen_inc == '0) gen_inc = GEN_BITS'(1);
    add_ok = (active_r < LAST) && (free_head_r < LAST) && !rd_active;
    hdl_ok = cur_ctrl_r.idx_ok && rd_active && (rd_gen == cur_gen_r);
  end

  // request evaluation, and the slot initialisation pass while clearing
  always_comb begin
    res_status    = ST_OK;
    res_idx       = '0;
    res_gen       = '0;
    res_typ       = '0;
    res_pay       = '0;
    free_head_nxt = free_head_r;
    active_nxt    = active_r;
    slot_we       = 1'b0;
    pay_we        = 1'b0;
    slot_wa       = cur_idx_r;
    slot_wd       = slot_rd_r;
    clr_cnt_nxt   = clr_cnt_r;
    if (state_r == BK_CLEAR) begin
      slot_we     = 1'b1;
      slot_wa     = clr_cnt_r;
      slot_wd     = {1'b0, GEN_BITS'(1), (clr_cnt_r == LAST) ? IDX_W'(0) : clr_cnt_r + IDX_W'(1)};
      clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
    end else if (cur_ctrl_r.op == OP_ADD) begin
      slot_wa = free_head_r;
      if (!add_ok) begin
        res_status = ST_FULL;
      end else begin
        slot_we       = fire;
        pay_we        = fire;
        slot_wd       = {1'b1, gen_inc, IDX_W'(0)};
        free_head_nxt = rd_next;
        active_nxt    = active_r + IDX_W'(1);
        res_idx       = free_head_r;
        res_gen       = gen_inc;
        res_typ       = cur_typ_r;
      end
    end else if (!hdl_ok) begin
      res_status = ST_STALE;
    end else begin
      case (cur_ctrl_r.op)
        OP_UPDATE: pay_we = fire;
        OP_REMOVE: begin
          slot_we       = fire;
          slot_wd       = {1'b0, rd_gen, free_head_r};
          free_head_nxt = cur_idx_r;
          active_nxt    = active_r - IDX_W'(1);
        end
        OP_GET:  res_pay = pay_rd_r;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire)           out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        free_head_r <= free_head_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctrl_r <= q_ctrl;
      cur_idx_r  <= q_idx;
      cur_gen_r  <= q_gen;
      cur_typ_r  <= q_typ;
      cur_pay_r  <= q_pay;
    end
    if (fire) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_gen_r    <= res_gen;
      out_typ_r    <= res_typ;
      out_pay_r    <= res_pay;
      out_live_r   <= active_nxt;
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (rd_en)   slot_rd_r <= slot_mem[rd_addr];
  end

  // payload store, no reset content
  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[slot_wa] <= cur_pay_r;
    if (rd_en)  pay_rd_r <= pay_mem[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_new_index      = out_idx_r;
  assign out_new_generation = out_gen_r;
  assign out_new_type       = out_typ_r;
  assign out_payload_out    = out_pay_r;
  assign out_live_count     = out_live_r;

endmodule

>>> rtl/generational_handle_table.sv
// Top level of the generational handle table.
//
// Handle table with a LIFO free list and a generation counter per slot.
// Input channel in_*: one request per handshake (add, update, remove, get).
// Result channel out_*: exactly one result per request, in request order.
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low.
// A request passes the queue, the slot read and the result register to
// out_valid, held up while the back end is busy with an earlier request
// or the receiver stalls. The back end runs one request at a time, set by
// the read-then-write through the slot store's single read and write ports.
// A two-entry queue sits between intake and execution, and the result
// register lets the next request be taken while a result waits.
// Reset: after rst_n the slot store is initialised by a pass of ENTRIES
// cycles, during which in_stall stays high.
// Receiver stall: the result is held; execution waits, the queue fills and
// in_stall then rises.
`timescale 1ns / 1ps
module generational_handle_table import ght_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int GEN_BITS     = GEN_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int IDX_W       = $clog2(ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [IDX_W-1:0]        in_handle_index,
  input  logic [GEN_BITS-1:0]     in_handle_generation,
  input  logic [TYPE_W-1:0]       in_handle_type,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [IDX_W-1:0]        out_new_index,
  output logic [GEN_BITS-1:0]     out_new_generation,
  output logic [TYPE_W-1:0]       out_new_type,
  output logic [PAYLOAD_BITS-1:0] out_payload_out,
  output logic [IDX_W-1:0]        out_live_count
);

  logic                    clearing, q_pop, q_valid;
  req_ctrl_t               q_ctrl;
  logic [IDX_W-1:0]        q_idx;
  logic [GEN_BITS-1:0]     q_gen;
  logic [TYPE_W-1:0]       q_typ;
  logic [PAYLOAD_BITS-1:0] q_pay;

  ght_front #(
    .ENTRIES      (ENTRIES),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .in_handle_type       (in_handle_type),
    .in_payload           (in_payload),
    .clearing             (clearing),
    .q_pop                (q_pop),
    .q_valid              (q_valid),
    .q_ctrl               (q_ctrl),
    .q_idx                (q_idx),
    .q_gen                (q_gen),
    .q_typ                (q_typ),
    .q_pay                (q_pay)
  );

  ght_back #(
    .ENTRIES      (ENTRIES),
    .GEN_BITS     (GEN_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_ctrl             (q_ctrl),
    .q_idx              (q_idx),
    .q_gen              (q_gen),
    .q_typ              (q_typ),
    .q_pay              (q_pay),
    .q_pop              (q_pop),
    .clearing           (clearing),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_new_index      (out_new_index),
    .out_new_generation (out_new_generation),
    .out_new_type       (out_new_type),
    .out_payload_out    (out_payload_out),
    .out_live_count     (out_live_count)
  );

endmodule
